### hdl/lbs_pkg.sv
// Shared constants, item type and field layout for the skinning block.
package lbs_pkg;

	localparam int JOINTS       = 32;
	localparam int ROWS         = 3;
	localparam int COLS         = 4;
	localparam int ENTRIES      = ROWS * COLS;
	localparam int RAM_DEPTH    = JOINTS * ROWS;
	localparam int RAM_AW       = $clog2(RAM_DEPTH);
	localparam int COL_W        = 2;
	localparam int ROW_W        = 2;
	localparam int JOINT_W      = 5;
	localparam int ENTRY_W      = 4;
	localparam int VAL_W        = 32;
	localparam int WEIGHT_W     = 17;
	localparam int SUM_W        = 48;
	localparam int S_TDATA_W    = 160;
	localparam int M_TDATA_W    = 96;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

	// Input tdata layout, lowest bit first
	localparam int JOINT_LSB    = 0;
	localparam int ENTRY_LSB    = JOINT_LSB + JOINT_W;
	localparam int MVAL_LSB     = ENTRY_LSB + ENTRY_W;
	localparam int BX_LSB       = MVAL_LSB + VAL_W;
	localparam int BY_LSB       = BX_LSB + VAL_W;
	localparam int BZ_LSB       = BY_LSB + VAL_W;
	localparam int WEIGHT_LSB   = BZ_LSB + VAL_W;

	// Values of the action selector
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TERM = 1'b1;

	// One classified item as it travels from front to back
	typedef struct packed {
		logic                       is_term;
		logic                       wr_ok;
		logic                       active;
		logic                       last;
		logic [JOINT_W-1:0]         joint;
		logic [ROW_W-1:0]           row;
		logic [COL_W-1:0]           col;
		logic signed [VAL_W-1:0]    mval;
		logic signed [VAL_W-1:0]    bx;
		logic signed [VAL_W-1:0]    by;
		logic signed [VAL_W-1:0]    bz;
		logic [WEIGHT_W-1:0]        weight;
	} item_t;

	// Row address of a joint's matrix row in the column memories
	function automatic logic [RAM_AW-1:0] row_addr(input logic [JOINT_W-1:0] j,
			input logic [ROW_W-1:0] r);
		row_addr = RAM_AW'(RAM_AW'(j) * RAM_AW'(ROWS) + RAM_AW'(r));
	endfunction

endpackage

### hdl/lbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/lbs_front.sv
// Front end: threshold register, input transfer and item classification.
module lbs_front import lbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [WEIGHT_W-1:0]  cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tuser,
	input  logic                 s_axis_tlast,
	input  logic                 q_full,
	output logic                 q_push,
	output item_t                q_item
);

	logic [WEIGHT_W-1:0] thresh_q;
	logic [JOINT_W-1:0]  joint;
	logic [ENTRY_W-1:0]  entry;
	logic [WEIGHT_W-1:0] weight;
	logic                joint_ok;

	// Hold the weight threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= '0;
		end else if (cfg_valid) begin
			thresh_q <= cfg_data;
		end
	end

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	assign joint    = s_axis_tdata[JOINT_LSB +: JOINT_W];
	assign entry    = s_axis_tdata[ENTRY_LSB +: ENTRY_W];
	assign weight   = s_axis_tdata[WEIGHT_LSB +: WEIGHT_W];
	assign joint_ok = 32'(joint) < JOINTS;

	// Classify: loads get a row/column slot, terms a clamped weight and skip flag
	always_comb begin
		q_item         = '0;
		q_item.is_term = (s_axis_tuser == ACT_TERM);
		q_item.wr_ok   = (32'(entry) < ENTRIES) && joint_ok;
		q_item.active  = (weight > thresh_q) && joint_ok;
		q_item.last    = s_axis_tlast;
		q_item.joint   = joint;
		q_item.row     = entry[ENTRY_W-1 -: ROW_W];
		q_item.col     = entry[COL_W-1:0];
		q_item.mval    = s_axis_tdata[MVAL_LSB +: VAL_W];
		q_item.bx      = s_axis_tdata[BX_LSB +: VAL_W];
		q_item.by      = s_axis_tdata[BY_LSB +: VAL_W];
		q_item.bz      = s_axis_tdata[BZ_LSB +: VAL_W];
		q_item.weight  = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
	end

endmodule

### hdl/lbs_queue.sv
// Two-entry queue of classified items between front and back.
module lbs_queue import lbs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	item_t       slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = slot_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/lbs_back.sv
// Back end: matrix memories, shared multiplier sequencer, accumulators, output register.
module lbs_back import lbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  item_t                q_item,
	output logic                 q_pop,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_MAC  = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	localparam logic [2:0] STEP_LAST = 3'd5;
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

	logic [1:0]              state_q;
	item_t                   cur_q;
	logic [ROW_W-1:0]        row_q;
	logic [2:0]              step_q;
	logic signed [63:0]      prod_q;
	logic signed [49:0]      t_q;
	logic signed [64:0]      wprod_q;
	logic signed [SUM_W-1:0] sum_q [ROWS];
	logic                    out_valid_q;
	logic [M_TDATA_W-1:0]    out_data_q;

	logic [VAL_W-1:0]        rdata [COLS];
	logic                    ram_we;
	logic [RAM_AW-1:0]       waddr;
	logic [RAM_AW-1:0]       raddr;
	logic                    ram_re;
	logic signed [VAL_W-1:0] mul_a;
	logic signed [VAL_W-1:0] mul_b;
	logic signed [49:0]      prod_fl;
	logic signed [49:0]      sum_next;
	logic signed [SUM_W-1:0] t_sat;
	logic                    emit_go;

	function automatic logic signed [SUM_W-1:0] sat48(input logic signed [49:0] v);
		if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
			sat48 = v[SUM_W-1:0];
		end else if (v[49]) begin
			sat48 = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			sat48 = {1'b0, {(SUM_W-1){1'b1}}};
		end
	endfunction

	function automatic logic [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		if (v[SUM_W-1:31] == '0 || v[SUM_W-1:31] == '1) begin
			sat32 = v[VAL_W-1:0];
		end else if (v[SUM_W-1]) begin
			sat32 = 32'h8000_0000;
		end else begin
			sat32 = 32'h7FFF_FFFF;
		end
	endfunction

	// Memory control: loads write at queue pop, rows are read one per term row
	assign q_pop  = (state_q == S_IDLE) && q_valid;
	assign ram_we = q_pop && !q_item.is_term && q_item.wr_ok;
	assign waddr  = row_addr(q_item.joint, q_item.row);
	assign ram_re = (state_q == S_RD);
	assign raddr  = row_addr(cur_q.joint, row_q);

	for (genvar c = 0; c < COLS; c++) begin : g_col
		lbs_ram #(
			.WIDTH(VAL_W),
			.DEPTH(RAM_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (ram_we && (q_item.col == COL_W'(c))),
			.waddr(waddr),
			.wdata(q_item.mval),
			.re   (ram_re),
			.raddr(raddr),
			.rdata(rdata[c])
		);
	end

	// Select multiplier operands for the current column
	always_comb begin
		case (step_q)
			3'd0: begin
				mul_a = rdata[0];
				mul_b = cur_q.bx;
			end
			3'd1: begin
				mul_a = rdata[1];
				mul_b = cur_q.by;
			end
			3'd2: begin
				mul_a = rdata[2];
				mul_b = cur_q.bz;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_fl  = {{2{prod_q[63]}}, prod_q[63:16]};
	assign t_sat    = sat48(t_q);
	assign sum_next = {{2{sum_q[row_q][SUM_W-1]}}, sum_q[row_q]}
		+ {{1{wprod_q[64]}}, wprod_q[64:16]};
	assign emit_go  = !out_valid_q || m_axis_tready;

	// Datapath registers of the multiply sequence
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (state_q == S_MAC) begin
			case (step_q)
				3'd0:    prod_q <= mul_a * mul_b;
				3'd1: begin
					t_q    <= {{18{rdata[3][VAL_W-1]}}, rdata[3]} + prod_fl;
					prod_q <= mul_a * mul_b;
				end
				3'd2: begin
					t_q    <= t_q + prod_fl;
					prod_q <= mul_a * mul_b;
				end
				3'd3:    t_q <= t_q + prod_fl;
				3'd4:    wprod_q <= t_sat * $signed({1'b0, cur_q.weight});
				default: t_q <= t_q;
			endcase
		end
		if (state_q == S_EMIT && emit_go) begin
			out_data_q <= {sat32(sum_q[2]), sat32(sum_q[1]), sat32(sum_q[0])};
		end
	end

	// Sequencer, accumulators and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < ROWS; r++) begin
				sum_q[r] <= '0;
			end
		end else begin
			// Raise valid when the sums move out, drop it after the transfer
			if (state_q == S_EMIT && emit_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					row_q  <= '0;
					step_q <= '0;
					if (q_valid && q_item.is_term) begin
						if (q_item.active) begin
							state_q <= S_RD;
						end else if (q_item.last) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_RD: begin
					step_q  <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					if (step_q == STEP_LAST) begin
						sum_q[row_q] <= sat48(sum_next);
						if (row_q == ROW_LAST) begin
							state_q <= cur_q.last ? S_EMIT : S_IDLE;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= S_RD;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						for (int r = 0; r < ROWS; r++) begin
							sum_q[r] <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

### hdl/linear_blend_vertex_skinning_top.sv
// Top level of the linear blend skinning block: front, queue and back.
//
//  channel   direction  signals                          content
//  cfg       in         cfg_valid/ready, cfg_data[16:0]  weight threshold, Q1.16
//  s_axis    in         tvalid/tready/tdata/tuser/tlast  load items and vertex terms
//  m_axis    out        tvalid/tready/tdata              skinned vertex, Q16.16
//
// A load is written to memory as it leaves the queue. A term above the
// threshold leaves the queue, then runs three matrix rows, each one memory
// read plus six steps (three column products on the shared multiplier, then
// the weight product); a skipped term only leaves the queue. After a last
// term the sums move into the output register once it is free. Reset
// clears the accumulators and threshold; the matrix memory is not cleared.
// The two-entry queue holds up to two input items while the back end works.
module linear_blend_vertex_skinning_top import lbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [WEIGHT_W-1:0]  cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// joint[4:0], entry[8:5], matrix_value[40:9], bind_x[72:41],
	// bind_y[104:73], bind_z[136:105], weight[153:137], zeros[159:154]
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tuser,   // action[0]
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// skinned_x[31:0], skinned_y[63:32], skinned_z[95:64]
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	logic  q_full;
	logic  q_push;
	item_t q_push_item;
	logic  q_pop;
	logic  q_valid;
	item_t q_head;

	lbs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_push_item)
	);

	lbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_item (q_head)
	);

	lbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_head),
		.q_pop        (q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule
